// ===== src/dnsv_pkg.sv =====
package dnsv_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int TOTAL_W     = 9;
    localparam int LABEL_W     = 7;
    localparam int MAX_LABEL_W = 6;
    localparam int PEND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Counter limits
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 9'd257;
    localparam logic [TOTAL_W-1:0] TOTAL_CAP = 9'd256;
    localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd64;

    // Byte classes
    localparam logic [BYTE_W-1:0] CTRL_LAST = 8'h1F;
    localparam logic [BYTE_W-1:0] DEL_BYTE  = 8'h7F;
    localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;
    localparam logic [1:0]        CONT_TAG  = 2'b10;
    localparam logic [2:0]        LEAD2_TAG = 3'b110;
    localparam logic [3:0]        LEAD3_TAG = 4'b1110;
    localparam logic [4:0]        LEAD4_TAG = 5'b11110;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 2'd2;

    // Register reset values
    localparam logic [TOTAL_W-1:0]     RST_MAX_TOTAL = 9'd256;
    localparam logic                   RST_LABEL_EN  = 1'b1;
    localparam logic [MAX_LABEL_W-1:0] RST_MAX_LABEL = 6'd63;

    typedef struct packed {
        logic [TOTAL_W-1:0]     max_total;
        logic                   label_en;
        logic [MAX_LABEL_W-1:0] max_label;
    } t_cfg;

endpackage

// ===== src/dnsv_tracker.sv =====
module dnsv_tracker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dnsv_pkg::t_cfg            i_cfg,
    input  logic                      i_advance,
    input  logic [dnsv_pkg::BYTE_W-1:0] i_byte,
    input  logic                      i_last,
    input  logic                      i_none,
    output logic                      o_name_valid
);
    import dnsv_pkg::*;

    logic [TOTAL_W-1:0] r_total, n_total;
    logic [LABEL_W-1:0] r_label, n_label;
    logic [PEND_W-1:0]  r_pend,  n_pend;
    logic               r_fail,  n_fail;

    logic [TOTAL_W-1:0] s_total;
    logic [LABEL_W-1:0] s_label;
    logic [PEND_W-1:0]  s_pend;
    logic               s_fail;
    logic [TOTAL_W-1:0] limit;
    logic               done;

    // Take one byte into the running name state
    always_comb begin
        n_total = (r_total < TOTAL_SAT) ? r_total + TOTAL_W'(1) : r_total;
        n_label = r_label;
        n_pend  = r_pend;
        n_fail  = r_fail;

        if (i_byte <= CTRL_LAST || i_byte == DEL_BYTE) begin
            n_fail = 1'b1;
        end

        if (r_pend != '0) begin
            if (i_byte[7:6] != CONT_TAG) begin
                n_fail = 1'b1;
            end
            n_pend = r_pend - PEND_W'(1);
        end else if (!i_byte[7]) begin
            n_pend = r_pend;
        end else if (i_byte[7:5] == LEAD2_TAG) begin
            n_pend = PEND_W'(1);
        end else if (i_byte[7:4] == LEAD3_TAG) begin
            n_pend = PEND_W'(2);
        end else if (i_byte[7:3] == LEAD4_TAG) begin
            n_pend = PEND_W'(3);
        end else begin
            n_fail = 1'b1;
        end

        if (i_cfg.label_en) begin
            if (i_byte == DOT_BYTE) begin
                if (r_label > {1'b0, i_cfg.max_label}) begin
                    n_fail = 1'b1;
                end
                n_label = '0;
            end else if (r_label < LABEL_SAT) begin
                n_label = r_label + LABEL_W'(1);
            end
        end
    end

    // Judge the name: an empty-name mark judges what is already held
    always_comb begin
        s_total = i_none ? r_total : n_total;
        s_label = i_none ? r_label : n_label;
        s_pend  = i_none ? r_pend  : n_pend;
        s_fail  = i_none ? r_fail  : n_fail;
        limit   = (i_cfg.max_total > TOTAL_CAP) ? TOTAL_CAP : i_cfg.max_total;
        o_name_valid = !s_fail && (s_pend == '0) && (s_total <= limit)
                     && !(i_cfg.label_en && (s_label > {1'b0, i_cfg.max_label}));
    end

    assign done = i_none || i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_label <= '0;
            r_pend  <= '0;
            r_fail  <= 1'b0;
        end else if (i_advance) begin
            if (done) begin
                r_total <= '0;
                r_label <= '0;
                r_pend  <= '0;
                r_fail  <= 1'b0;
            end else begin
                r_total <= n_total;
                r_label <= n_label;
                r_pend  <= n_pend;
                r_fail  <= n_fail;
            end
        end
    end

    a_total_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_SAT)
        else $error("total count beyond saturation");

    a_label_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label <= LABEL_SAT)
        else $error("label count beyond saturation");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && done |=> r_total == '0 && r_label == '0 && r_pend == '0 && !r_fail)
        else $error("name state not cleared after result");

    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail && !(i_advance && done) |=> r_fail)
        else $error("failure flag dropped within a name");

endmodule

// ===== src/dnssd_name_text_validator_unit.sv =====
// Path from an accepted input item to its result on the master side:
// input register, then the checking logic into the result register.
// Throughput: 1 byte per cycle; the input register stalls only when a
// name-ending item meets a full result register that is not being taken.
// Reset (i_rst_n low, synchronous): pipeline emptied, name state cleared,
// registers return to 256 / label checking on / 63.
module dnssd_name_text_validator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dnsv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dnsv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Slave side: name bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tlast,  // last_byte
    input  logic                             s_axis_tuser,  // [0] no_bytes
    // Master side: one verdict per name
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata   // [0] name_valid, [7:1] zero
);
    import dnsv_pkg::*;

    // Configuration registers; writes are always taken
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_total <= RST_MAX_TOTAL;
            r_cfg.label_en  <= RST_LABEL_EN;
            r_cfg.max_label <= RST_MAX_LABEL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_TOTAL: r_cfg.max_total <= i_cfg_data[TOTAL_W-1:0];
                CFG_LABEL_EN:  r_cfg.label_en  <= i_cfg_data[0];
                CFG_MAX_LABEL: r_cfg.max_label <= i_cfg_data[MAX_LABEL_W-1:0];
                default:       r_cfg           <= r_cfg;  // unknown index: drop
            endcase
        end
    end

    // Input register: holds one item until the checker takes it
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_in_none;

    // Result register
    logic r_out_valid;
    logic r_out_name_valid;

    logic ends_name;
    logic out_free;
    logic advance;
    logic name_valid;

    // An item that ends a name needs room in the result register;
    // any other item advances as soon as it sits in the input register.
    assign ends_name     = r_in_last || r_in_none;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!ends_name || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
            r_in_none <= s_axis_tuser;
        end
    end

    dnsv_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_none       (r_in_none),
        .o_name_valid (name_valid)
    );

    // Load a verdict when a name ends, otherwise drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && ends_name) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ends_name) begin
            r_out_name_valid <= name_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_name_valid};

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid && ends_name))
        else $error("result appeared without a name-ending item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && ends_name |-> !r_out_valid || m_axis_tready)
        else $error("pending result overwritten");

    a_held_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("stalled input item lost");

endmodule
